/* hw/rtl/frt_pkg.sv */
// Package: shared constants and types for the fragment reassembly tracker.
`default_nettype none
package frt_pkg;

  localparam int SLOTS         = 8;
  localparam int MAX_FRAGMENTS = 64;

  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int FRAG_IDX_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int SEQ_W      = 16;
  localparam int RCV_W      = 7;
  localparam int TYPE_W     = 8;

  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_MISMATCH   = 3'd1,
    ST_DUPLICATE  = 3'd2,
    ST_BAD_INDEX  = 3'd3,
    ST_TABLE_FULL = 3'd4,
    ST_RESET_DONE = 3'd5,
    ST_COUNT_BIG  = 3'd6
  } status_t;

  typedef enum logic {
    FUNC_FRAGMENT = 1'b0,
    FUNC_RESET    = 1'b1
  } func_t;

endpackage
`default_nettype wire

/* hw/rtl/frt_if.sv */
// Interfaces: fragment header channel and result channel.
`default_nettype none
interface frt_frag_if;
  import frt_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [SEQ_W-1:0]  seq_number;
  logic [SEQ_W-1:0]  frag_index;
  logic [SEQ_W-1:0]  frag_count;
  logic              should_ack;
  logic [TYPE_W-1:0] data_type;

  modport source (output valid, func, seq_number, frag_index, frag_count, should_ack,
                  data_type, input ready);
  modport sink   (input valid, func, seq_number, frag_index, frag_count, should_ack,
                  data_type, output ready);
endinterface

interface frt_result_if;
  import frt_pkg::*;

  logic              valid;
  logic              ready;
  status_t           status;
  logic [SEQ_W-1:0]  start_seq;
  logic [RCV_W-1:0]  received_count;
  logic [SEQ_W-1:0]  total_count;
  logic              progress_valid;
  logic              message_complete;
  logic [TYPE_W-1:0] msg_type;
  logic              ack_valid;
  logic [SEQ_W-1:0]  ack_seq;

  modport source (output valid, status, start_seq, received_count, total_count,
                  progress_valid, message_complete, msg_type, ack_valid, ack_seq,
                  input ready);
  modport sink   (input valid, status, start_seq, received_count, total_count,
                  progress_valid, message_complete, msg_type, ack_valid, ack_seq,
                  output ready);
endinterface
`default_nettype wire

/* hw/rtl/fragment_reassembly_tracker_core.sv */
// Top level: slot table lookup, fragment bookkeeping and result register.
//
//   channel  | dir | payload
//   ---------+-----+---------------------------------------------------------
//   frag     | in  | func, seq_number, frag_index, frag_count, should_ack,
//            |     | data_type
//   result   | out | status, start_seq, received_count, total_count,
//            |     | progress_valid, message_complete, msg_type, ack_valid, ack_seq
//
// One item per cycle unless result stalls; result is valid the cycle after acceptance.
// The slot compare, bitmap update and completion check run in the accept cycle.
// frag.ready is high whenever the result register is empty or being drained.
// Reset clears all slot valid bits and the result valid; slot payload is not reset.
`default_nettype none
module fragment_reassembly_tracker_core (
  input  wire logic    clk,
  input  wire logic    rst,
  frt_frag_if.sink     frag,
  frt_result_if.source result
);
  import frt_pkg::*;

  logic [SLOTS-1:0]         slot_valid;
  logic [SEQ_W-1:0]         slot_start_seq [SLOTS];
  logic [SEQ_W-1:0]         slot_total     [SLOTS];
  logic [RCV_W-1:0]         slot_received  [SLOTS];
  logic [TYPE_W-1:0]        slot_type      [SLOTS];
  logic [MAX_FRAGMENTS-1:0] slot_bitmap    [SLOTS];

  logic                     accept;
  logic [SEQ_W-1:0]         key;
  logic [SLOTS-1:0]         match;
  logic                     hit;
  logic                     has_free;
  logic [SLOT_W-1:0]        hit_idx;
  logic [SLOT_W-1:0]        free_idx;
  logic [SLOT_W-1:0]        sel;
  logic                     cnt_big;
  logic                     use_slot;
  logic                     opened;
  logic [SEQ_W-1:0]         tot;
  logic [RCV_W-1:0]         rcv_cur;
  logic [MAX_FRAGMENTS-1:0] bmp_cur;
  logic [TYPE_W-1:0]        typ_cur;
  logic [MAX_FRAGMENTS-1:0] mask;
  logic                     idx_ok;
  logic                     dup;
  logic                     mark;
  logic [RCV_W-1:0]         rcv_new;
  logic [MAX_FRAGMENTS-1:0] bmp_new;
  logic                     done;
  status_t                  status_next;

  assign frag.ready = !result.valid || result.ready;
  assign accept     = frag.valid && frag.ready;

  always_comb begin
    key      = frag.seq_number - frag.frag_index;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      match[i] = slot_valid[i] && (slot_start_seq[i] == key);
      if (match[i]) begin
        hit_idx = SLOT_W'(i);
      end
      if (!slot_valid[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
    hit      = |match;
    has_free = !(&slot_valid);
    cnt_big  = frag.frag_count > SEQ_W'(MAX_FRAGMENTS);
    use_slot = hit || (!cnt_big && has_free);
    opened   = !hit && use_slot;
    sel      = hit ? hit_idx : free_idx;

    tot     = hit ? slot_total[sel]    : frag.frag_count;
    rcv_cur = hit ? slot_received[sel] : '0;
    bmp_cur = hit ? slot_bitmap[sel]   : '0;
    typ_cur = hit ? slot_type[sel]     : frag.data_type;

    idx_ok = (frag.frag_index < tot) && (frag.frag_index < SEQ_W'(MAX_FRAGMENTS));
    mask   = MAX_FRAGMENTS'(1) << frag.frag_index[FRAG_IDX_W-1:0];
    dup    = |(bmp_cur & mask);
    mark   = 1'b0;

    priority if (!use_slot) begin
      status_next = cnt_big ? ST_COUNT_BIG : ST_TABLE_FULL;
    end else if (frag.frag_count != tot) begin
      status_next = ST_MISMATCH;
    end else if (!idx_ok) begin
      status_next = ST_BAD_INDEX;
    end else if (dup) begin
      status_next = ST_DUPLICATE;
    end else begin
      status_next = ST_ACCEPTED;
      mark        = 1'b1;
    end

    rcv_new = mark ? rcv_cur + RCV_W'(1) : rcv_cur;
    bmp_new = mark ? (bmp_cur | mask) : bmp_cur;
    done    = use_slot && ({{(SEQ_W - RCV_W){1'b0}}, rcv_new} == tot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      result.valid <= 1'b0;
    end else begin
      if (accept) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (accept) begin
        if (frag.func == FUNC_RESET) begin
          slot_valid <= '0;
        end else if (use_slot) begin
          slot_valid[sel] <= !done;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frag.func == FUNC_FRAGMENT && use_slot) begin
      slot_received[sel] <= rcv_new;
      slot_bitmap[sel]   <= bmp_new;
      if (opened) begin
        slot_start_seq[sel] <= key;
        slot_total[sel]     <= frag.frag_count;
        slot_type[sel]      <= frag.data_type;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (frag.func == FUNC_RESET) begin
        result.status           <= ST_RESET_DONE;
        result.start_seq        <= '0;
        result.received_count   <= '0;
        result.total_count      <= '0;
        result.progress_valid   <= 1'b0;
        result.message_complete <= 1'b0;
        result.msg_type         <= '0;
        result.ack_valid        <= 1'b0;
        result.ack_seq          <= '0;
      end else begin
        result.status           <= status_next;
        result.start_seq        <= key;
        result.received_count   <= use_slot ? rcv_new : '0;
        result.total_count      <= tot;
        result.progress_valid   <= use_slot && (tot != SEQ_W'(1));
        result.message_complete <= done;
        result.msg_type         <= typ_cur;
        result.ack_valid        <= frag.should_ack;
        result.ack_seq          <= frag.should_ack ? frag.seq_number : '0;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/frt_checker.sv */
// Checker: port-level assertions for the tracker core, with its bind.
`default_nettype none
module frt_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  frag_valid,
  input wire logic                  frag_ready,
  input wire logic                  func,
  input wire logic                  result_valid,
  input wire logic                  result_ready,
  input wire frt_pkg::status_t      status,
  input wire logic [6:0]            received_count,
  input wire logic [15:0]           total_count,
  input wire logic                  message_complete,
  input wire logic                  ack_valid
);
  import frt_pkg::*;

  logic frag_acc;
  assign frag_acc = frag_valid && frag_ready;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(status)
      && $stable(received_count) && $stable(total_count))
    else $error("result changed while stalled");

  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    frag_acc |=> result_valid)
    else $error("accepted item produced no result");

  a_reset_item: assert property (@(posedge clk) disable iff (rst)
    frag_acc && func |=> status == ST_RESET_DONE)
    else $error("reset item did not report reset done");

  a_reset_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_RESET_DONE |-> received_count == 7'd0
      && total_count == 16'd0 && !ack_valid && !message_complete)
    else $error("reset result carries nonzero fields");

  a_complete_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && message_complete |-> {9'd0, received_count} == total_count)
    else $error("completion reported with counts unequal");

endmodule

bind fragment_reassembly_tracker_core frt_checker u_frt_checker (
  .clk              (clk),
  .rst              (rst),
  .frag_valid       (frag.valid),
  .frag_ready       (frag.ready),
  .func             (frag.func),
  .result_valid     (result.valid),
  .result_ready     (result.ready),
  .status           (result.status),
  .received_count   (result.received_count),
  .total_count      (result.total_count),
  .message_complete (result.message_complete),
  .ack_valid        (result.ack_valid)
);
`default_nettype wire

/* tb/tb_fragment_reassembly_tracker_core.sv */
// Testbench for the fragment reassembly tracker: header traffic checked against a slot table.
`default_nettype none
module tb_fragment_reassembly_tracker_core;
  timeunit 1ns;
  timeprecision 1ps;
  import frt_pkg::*;

  typedef struct packed {
    func_t             func;
    logic [SEQ_W-1:0]  seq_number;
    logic [SEQ_W-1:0]  frag_index;
    logic [SEQ_W-1:0]  frag_count;
    logic              should_ack;
    logic [TYPE_W-1:0] data_type;
  } frag_item_t;

  typedef struct packed {
    status_t           status;
    logic [SEQ_W-1:0]  start_seq;
    logic [RCV_W-1:0]  received_count;
    logic [SEQ_W-1:0]  total_count;
    logic              progress_valid;
    logic              message_complete;
    logic [TYPE_W-1:0] msg_type;
    logic              ack_valid;
    logic [SEQ_W-1:0]  ack_seq;
  } frag_result_t;

  logic clk = 1'b0;
  logic rst;
  bit   idle_en = 1'b1;
  int   mismatch_count = 0;

  frag_result_t expected_results[$];

  // predicted slot table
  logic              slot_used  [SLOTS];
  logic [SEQ_W-1:0]  slot_key   [SLOTS];
  logic [SEQ_W-1:0]  slot_count [SLOTS];
  logic [RCV_W-1:0]  slot_rcvd  [SLOTS];
  logic [TYPE_W-1:0] slot_tag   [SLOTS];
  logic [63:0]       slot_seen  [SLOTS];

  frt_frag_if   frag_ch ();
  frt_result_if res_ch ();

  fragment_reassembly_tracker_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .frag   (frag_ch),
    .result (res_ch)
  );

  always #1 clk = ~clk;

  initial begin
    #200000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    res_ch.ready <= !idle_en || ($urandom_range(99) >= 13);
  end

  function automatic frag_result_t predict_result(input frag_item_t it);
    frag_result_t     r;
    logic [SEQ_W-1:0] key;
    logic [63:0]      bit_mask;
    int               hit;
    int               spare;
    r = '0;
    if (it.func == FUNC_RESET) begin
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      r.status = ST_RESET_DONE;
      return r;
    end
    key = it.seq_number - it.frag_index;
    r.ack_valid = it.should_ack;
    r.ack_seq = it.should_ack ? it.seq_number : '0;
    hit = -1;
    spare = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && hit < 0 && slot_key[i] == key) hit = i;
      if (!slot_used[i] && spare < 0) spare = i;
    end
    if (hit < 0) begin
      if (it.frag_count > MAX_FRAGMENTS || spare < 0) begin
        r.status = (it.frag_count > MAX_FRAGMENTS) ? ST_COUNT_BIG : ST_TABLE_FULL;
        r.start_seq = key;
        r.total_count = it.frag_count;
        r.msg_type = it.data_type;
        return r;
      end
      hit = spare;
      slot_used[hit] = 1'b1;
      slot_key[hit] = key;
      slot_count[hit] = it.frag_count;
      slot_rcvd[hit] = '0;
      slot_tag[hit] = it.data_type;
      slot_seen[hit] = '0;
    end
    if (it.frag_count != slot_count[hit]) begin
      r.status = ST_MISMATCH;
    end else if (it.frag_index < slot_count[hit] && it.frag_index < 64) begin
      bit_mask = 64'd1 << it.frag_index[5:0];
      if ((slot_seen[hit] & bit_mask) != '0) begin
        r.status = ST_DUPLICATE;
      end else begin
        slot_seen[hit] = slot_seen[hit] | bit_mask;
        slot_rcvd[hit] = slot_rcvd[hit] + 1'b1;
        r.status = ST_ACCEPTED;
      end
    end else begin
      r.status = ST_BAD_INDEX;
    end
    r.start_seq = slot_key[hit];
    r.received_count = slot_rcvd[hit];
    r.total_count = slot_count[hit];
    r.progress_valid = (slot_count[hit] != 16'd1);
    r.message_complete = ({9'd0, slot_rcvd[hit]} == slot_count[hit]);
    r.msg_type = slot_tag[hit];
    if (r.message_complete) slot_used[hit] = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    frag_result_t got;
    frag_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.status = res_ch.status;
      got.start_seq = res_ch.start_seq;
      got.received_count = res_ch.received_count;
      got.total_count = res_ch.total_count;
      got.progress_valid = res_ch.progress_valid;
      got.message_complete = res_ch.message_complete;
      got.msg_type = res_ch.msg_type;
      got.ack_valid = res_ch.ack_valid;
      got.ack_seq = res_ch.ack_seq;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: st=%0d start=%h rcv=%0d", got.status, got.start_seq,
                   got.received_count);
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status || got.start_seq != want.start_seq ||
            got.received_count != want.received_count || got.total_count != want.total_count ||
            got.progress_valid != want.progress_valid ||
            got.message_complete != want.message_complete ||
            got.msg_type != want.msg_type || got.ack_valid != want.ack_valid ||
            got.ack_seq != want.ack_seq) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display({"mismatch exp: st=%0d start=%h rcv=%0d tot=%0d",
                      " prog=%b done=%b type=%h ack=%b/%h"},
                     want.status, want.start_seq, want.received_count, want.total_count,
                     want.progress_valid, want.message_complete, want.msg_type,
                     want.ack_valid, want.ack_seq);
            $display({"         got: st=%0d start=%h rcv=%0d tot=%0d",
                      " prog=%b done=%b type=%h ack=%b/%h"},
                     got.status, got.start_seq, got.received_count, got.total_count,
                     got.progress_valid, got.message_complete, got.msg_type,
                     got.ack_valid, got.ack_seq);
          end
        end
      end
    end
  end

  task automatic send_item(input frag_item_t it);
    while (idle_en && $urandom_range(99) < 13) begin
      frag_ch.valid <= 1'b0;
      @(posedge clk);
    end
    frag_ch.valid <= 1'b1;
    frag_ch.func <= it.func;
    frag_ch.seq_number <= it.seq_number;
    frag_ch.frag_index <= it.frag_index;
    frag_ch.frag_count <= it.frag_count;
    frag_ch.should_ack <= it.should_ack;
    frag_ch.data_type <= it.data_type;
    @(posedge clk);
    while (!frag_ch.ready) @(posedge clk);
    expected_results.push_back(predict_result(it));
  endtask

  task automatic wait_results_drained();
    frag_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic frag_item_t frag_hdr(input logic [SEQ_W-1:0] seq, input logic [SEQ_W-1:0] idx,
                                          input logic [SEQ_W-1:0] cnt, input logic ack,
                                          input logic [TYPE_W-1:0] tag);
    frag_item_t it;
    it.func = FUNC_FRAGMENT;
    it.seq_number = seq;
    it.frag_index = idx;
    it.frag_count = cnt;
    it.should_ack = ack;
    it.data_type = tag;
    return it;
  endfunction

  // reset item carries random junk in the other fields
  function automatic frag_item_t reset_hdr();
    frag_item_t it;
    it = frag_hdr(SEQ_W'($urandom), SEQ_W'($urandom), SEQ_W'($urandom),
                  1'($urandom_range(1)), TYPE_W'($urandom));
    it.func = FUNC_RESET;
    return it;
  endfunction

  function automatic frag_item_t noise_hdr();
    frag_item_t it;
    it = frag_hdr(SEQ_W'($urandom), SEQ_W'($urandom), SEQ_W'($urandom),
                  1'($urandom_range(1)), TYPE_W'($urandom));
    if ($urandom_range(9) == 0) it.func = FUNC_RESET;
    if ($urandom_range(3) == 0) it.frag_index = SEQ_W'($urandom_range(7));
    if ($urandom_range(7) == 0) it.frag_count = SEQ_W'($urandom_range(3));
    return it;
  endfunction

  function automatic int pick_bit(input logic [63:0] bits, input int width);
    int p;
    p = $urandom_range(width - 1);
    while (!bits[p]) p = (p + 1) % width;
    return p;
  endfunction

  // concurrent messages in shuffled fragment order, with broken items mixed in
  task automatic run_traffic(input int n_items, input int n_lanes, input int calm_from,
                             input int calm_to);
    logic [SEQ_W-1:0]  lane_key  [16];
    int                lane_cnt  [16];
    logic [TYPE_W-1:0] lane_tag  [16];
    logic [63:0]       lane_todo [16];
    logic [63:0]       lane_full [16];
    logic [63:0]       sent_bits;
    frag_item_t        it;
    int                lane;
    int                r;
    int                pick;
    for (int l = 0; l < 16; l++) lane_todo[l] = '0;
    for (int n = 0; n < n_items; n++) begin
      idle_en = !(n >= calm_from && n < calm_to);
      lane = $urandom_range(n_lanes - 1);
      if (lane_todo[lane] == '0) begin
        r = $urandom_range(99);
        lane_key[lane] = SEQ_W'($urandom);
        lane_tag[lane] = TYPE_W'($urandom);
        lane_cnt[lane] = (r < 85) ? $urandom_range(8, 1) :
                         (r < 96) ? $urandom_range(32, 9) : $urandom_range(64, 33);
        lane_full[lane] = (lane_cnt[lane] == 64) ? '1 : (64'd1 << lane_cnt[lane]) - 64'd1;
        lane_todo[lane] = lane_full[lane];
      end
      sent_bits = ~lane_todo[lane] & lane_full[lane];
      it = frag_hdr(16'd0, 16'd0, SEQ_W'(lane_cnt[lane]), 1'($urandom_range(1)),
                    lane_tag[lane]);
      r = $urandom_range(99);
      if (r < 82 || (r < 86 && sent_bits == '0)) begin
        pick = pick_bit(lane_todo[lane], lane_cnt[lane]);
        lane_todo[lane][pick] = 1'b0;
        it.frag_index = SEQ_W'(pick);
      end else if (r < 86) begin
        it.frag_index = SEQ_W'(pick_bit(sent_bits, lane_cnt[lane]));
      end else if (r < 89) begin
        it.frag_index = SEQ_W'($urandom_range(lane_cnt[lane] - 1));
        it.frag_count = SEQ_W'(lane_cnt[lane] ^ (1 << $urandom_range(15)));
      end else if (r < 92) begin
        it.frag_index = SEQ_W'($urandom_range(65535, lane_cnt[lane]));
      end else if (r < 94) begin
        it.frag_index = SEQ_W'($urandom);
        it.frag_count = SEQ_W'($urandom_range(65535, MAX_FRAGMENTS + 1));
        lane_key[lane] = SEQ_W'($urandom);
        lane_todo[lane] = '0;
      end else if (r < 96) begin
        it = reset_hdr();
        for (int l = 0; l < 16; l++) lane_todo[l] = '0;
      end else begin
        it = noise_hdr();
      end
      if (r < 94) it.seq_number = lane_key[lane] + it.frag_index;
      send_item(it);
    end
    idle_en = 1'b1;
  endtask

  task automatic test_directed_cases();
    send_item(reset_hdr());
    send_item(frag_hdr(16'd100, 16'd0, 16'd1, 1'b1, 8'hff));      // single fragment
    send_item(frag_hdr(16'd200, 16'd0, 16'd0, 1'b0, 8'h11));      // zero count
    send_item(frag_hdr(16'hffff, 16'hffff, 16'hffff, 1'b1, 8'h22));
    send_item(frag_hdr(16'd3, 16'd5, 16'd64, 1'b0, 8'h00));       // key wraps below zero
    send_item(frag_hdr(16'd3, 16'd5, 16'd64, 1'b1, 8'h00));       // duplicate
    send_item(frag_hdr(16'd61, 16'd63, 16'd64, 1'b0, 8'h33));     // top bitmap bit
    send_item(frag_hdr(16'd62, 16'd64, 16'd64, 1'b1, 8'h33));     // index equals count
    send_item(frag_hdr(16'hfffe, 16'd0, 16'd10, 1'b0, 8'h33));    // count mismatch
    send_item(frag_hdr(16'd500, 16'd0, 16'd65, 1'b1, 8'h44));     // one above max count
    for (int k = 0; k < SLOTS - 1; k++)
      send_item(frag_hdr(SEQ_W'(1000 + k), 16'd0, 16'd2, k[0], TYPE_W'(8'h80 + k)));
    send_item(frag_hdr(16'd2000, 16'd0, 16'd3, 1'b1, 8'h55));     // table full
    send_item(frag_hdr(16'd1001, 16'd1, 16'd2, 1'b0, 8'h00));     // completes, frees slot
    send_item(frag_hdr(16'd2002, 16'd2, 16'd3, 1'b1, 8'h55));     // takes freed slot
    send_item(reset_hdr());
    send_item(frag_hdr(16'd1002, 16'd1, 16'd2, 1'b1, 8'haa));
    send_item(frag_hdr(16'd0, 16'd0, 16'd2, 1'b1, 8'h5a));
    send_item(frag_hdr(16'hffff, 16'hffff, 16'd2, 1'b0, 8'hff));  // huge index on open slot
    send_item(reset_hdr());
  endtask

  task automatic test_message_traffic();
    run_traffic(1200, 4, 300, 600);
  endtask

  task automatic test_table_pressure();
    run_traffic(400, 12, 0, 0);
  endtask

  task automatic test_random_noise();
    for (int n = 0; n < 300; n++) send_item(noise_hdr());
  endtask

  initial begin
    rst <= 1'b1;
    frag_ch.valid <= 1'b0;
    frag_ch.func <= FUNC_FRAGMENT;
    frag_ch.seq_number <= '0;
    frag_ch.frag_index <= '0;
    frag_ch.frag_count <= '0;
    frag_ch.should_ack <= 1'b0;
    frag_ch.data_type <= '0;
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    wait_results_drained();
    test_message_traffic();
    wait_results_drained();
    test_table_pressure();
    wait_results_drained();
    test_random_noise();
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/frt_pkg.sv
hw/rtl/frt_if.sv
hw/rtl/fragment_reassembly_tracker_core.sv
hw/rtl/frt_checker.sv
tb/tb_fragment_reassembly_tracker_core.sv
